### design/elex_pkg.sv
package elex_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;
    localparam int CNT_W = 3;

    localparam logic [CNT_W-1:0] KW_LEN = 3'd5;
    localparam logic [CNT_W-1:0] KW_HELD_MAX = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PRINT = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS = 4'd3;
    localparam logic [KIND_W-1:0] KIND_MINUS = 4'd4;
    localparam logic [KIND_W-1:0] KIND_STAR = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SLASH = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd8;
    localparam logic [KIND_W-1:0] KIND_EQUALS = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SEMI = 4'd10;
    localparam logic [KIND_W-1:0] KIND_ERROR = 4'd11;
    localparam logic [KIND_W-1:0] KIND_END = 4'd12;

    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_NUM = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_KW = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic end_of_input;
    } src_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [CHAR_W-1:0] char_out;
        logic token_start;
        logic last_in_run;
    } tok_beat_t;

    // results of one source byte: held keyword prefix, one more result, or all of print
    typedef struct packed {
        logic print;
        logic [CNT_W-1:0] flush_n;
        logic tail_valid;
        logic [KIND_W-1:0] tail_kind;
        logic [CHAR_W-1:0] tail_char;
        logic tail_start;
        logic [CNT_W-1:0] count;
    } burst_t;

    function automatic logic [CHAR_W-1:0] kw_char(input logic [CNT_W-1:0] i);
        logic [CHAR_W-1:0] ch;
        case (i)
            3'd0: ch = 8'h70;
            3'd1: ch = 8'h72;
            3'd2: ch = 8'h69;
            3'd3: ch = 8'h6E;
            3'd4: ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h2B: k = KIND_PLUS;
            8'h2D: k = KIND_MINUS;
            8'h2A: k = KIND_STAR;
            8'h2F: k = KIND_SLASH;
            8'h28: k = KIND_LPAREN;
            8'h29: k = KIND_RPAREN;
            8'h3D: k = KIND_EQUALS;
            8'h3B: k = KIND_SEMI;
            default: k = KIND_NUMBER;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

### design/elex_scan.sv
module elex_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  elex_pkg::src_beat_t beat,
    output elex_pkg::burst_t    burst
);
    import elex_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    always_comb
    begin
        logic [CHAR_W-1:0] c;
        mode_t             m;
        logic [CNT_W-1:0]  held;
        logic              done;
        logic [KIND_W-1:0] k;

        c = beat.char_in;
        m = mode_reg;
        done = 1'b0;
        k = op_kind(c);
        held = (cnt_reg > KW_HELD_MAX) ? KW_HELD_MAX : cnt_reg;

        mode_next = mode_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        burst = '0;

        if (beat.end_of_input)
        begin
            if (!err_reg && mode_reg == MODE_KW)
                burst.flush_n = held;
            burst.tail_valid = 1'b1;
            burst.tail_kind = KIND_END;
            burst.tail_char = '0;
            burst.tail_start = 1'b1;
            mode_next = MODE_START;
            cnt_next = '0;
            err_next = 1'b0;
        end
        else if (!err_reg)
        begin
            if (m == MODE_KW)
            begin
                if (cnt_reg < KW_LEN && c == kw_char(cnt_reg))
                begin
                    done = 1'b1;
                    if (cnt_reg + 3'd1 == KW_LEN)
                    begin
                        burst.print = 1'b1;
                        mode_next = MODE_START;
                        cnt_next = '0;
                    end
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
                else
                begin
                    burst.flush_n = held;
                    cnt_next = '0;
                    m = MODE_IDENT;
                end
            end
            if (!done && m == MODE_NUM)
            begin
                if (is_digit(c))
                begin
                    done = 1'b1;
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = KIND_NUMBER;
                    burst.tail_char = c;
                    burst.tail_start = 1'b0;
                    mode_next = MODE_NUM;
                end
                else
                    m = MODE_START;
            end
            if (!done && m == MODE_IDENT)
            begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE)
                begin
                    done = 1'b1;
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = KIND_IDENT;
                    burst.tail_char = c;
                    burst.tail_start = 1'b0;
                    mode_next = MODE_IDENT;
                end
                else
                    m = MODE_START;
            end
            if (!done)
            begin
                mode_next = MODE_START;
                burst.tail_char = c;
                burst.tail_start = 1'b1;
                if (is_space(c))
                    burst.tail_valid = 1'b0;
                else if (is_digit(c))
                begin
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = KIND_NUMBER;
                    mode_next = MODE_NUM;
                end
                else if (k != KIND_NUMBER)
                begin
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = k;
                end
                else if (c == kw_char(3'd0))
                begin
                    mode_next = MODE_KW;
                    cnt_next = 3'd1;
                end
                else if (is_alpha(c))
                begin
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = KIND_IDENT;
                    mode_next = MODE_IDENT;
                end
                else
                begin
                    burst.tail_valid = 1'b1;
                    burst.tail_kind = KIND_ERROR;
                    err_next = 1'b1;
                    cnt_next = '0;
                end
            end
        end

        if (burst.print)
            burst.count = KW_LEN;
        else
            burst.count = burst.flush_n + {2'b00, burst.tail_valid};
    end

    a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (mode_reg == MODE_START && cnt_reg == '0))
        else $error("latched error with scanner not parked");

    a_cnt_only_kw: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_KW) |-> (cnt_reg == '0))
        else $error("keyword count held outside keyword mode");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_KW) |-> (cnt_reg >= 3'd1 && cnt_reg <= KW_HELD_MAX))
        else $error("keyword count out of range");

endmodule

### design/elex_burst.sv
module elex_burst (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  elex_pkg::burst_t    burst,
    output logic                free,
    output logic                tok_valid,
    input  logic                tok_stall,
    output elex_pkg::tok_beat_t tok_beat
);
    import elex_pkg::*;

    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    burst_t           burst_reg;
    logic             take;
    logic             last;

    assign take = valid_reg && !tok_stall;
    assign last = (idx_reg == burst_reg.count - 3'd1);
    assign free = !valid_reg || (take && last);
    assign tok_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next = idx_reg;
        if (load)
        begin
            valid_next = (burst.count != '0);
            idx_next = '0;
        end
        else if (take)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
    end

    always_comb
    begin
        tok_beat.last_in_run = last;
        if (burst_reg.print)
        begin
            tok_beat.token_kind = KIND_PRINT;
            tok_beat.char_out = kw_char(idx_reg);
            tok_beat.token_start = (idx_reg == '0);
        end
        else if (idx_reg < burst_reg.flush_n)
        begin
            tok_beat.token_kind = KIND_IDENT;
            tok_beat.char_out = kw_char(idx_reg);
            tok_beat.token_start = (idx_reg == '0);
        end
        else
        begin
            tok_beat.token_kind = burst_reg.tail_kind;
            tok_beat.char_out = burst_reg.tail_char;
            tok_beat.token_start = burst_reg.tail_start;
        end
    end

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < burst_reg.count))
        else $error("beat index past end of burst");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("burst loaded over undelivered beats");

endmodule

### design/expression_lexer.sv
// pipeline: a source beat is registered in src_reg, decoded by the scanner once the burst stage is
// free, and its token beats are registered in the burst stage
// throughput: one source beat per cycle while each byte yields at most one token beat and tok_stall is low;
// a byte yielding n beats (up to 5) holds the source side until its last beat is taken
// reset: rst_n asynchronous active low; scanner at token start, error latch clear, no beats
module expression_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  elex_pkg::src_beat_t src_beat,
    output logic                tok_valid,
    input  logic                tok_stall,
    output elex_pkg::tok_beat_t tok_beat
);
    import elex_pkg::*;

    logic      src_valid_reg, src_valid_next;
    src_beat_t src_reg;
    logic      accept;
    logic      advance;
    logic      free;
    burst_t    burst;

    assign advance = src_valid_reg && free;
    assign src_stall = src_valid_reg && !free;
    assign accept = src_valid && !src_stall;

    always_comb
    begin
        src_valid_next = src_valid_reg;
        if (accept)
            src_valid_next = 1'b1;
        else if (advance)
            src_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            src_valid_reg <= 1'b0;
        else
            src_valid_reg <= src_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            src_reg <= src_beat;
    end

    elex_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .beat  (src_reg),
        .burst (burst)
    );

    elex_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .burst     (burst),
        .free      (free),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_beat  (tok_beat)
    );

    a_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_beat.token_kind == KIND_END) |->
            (tok_beat.token_start && tok_beat.last_in_run))
        else $error("end beat not a single-beat token");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import elex_pkg::*;

    class token_tracker;
        tok_beat_t pending_tokens[$];
        tok_beat_t run_tokens[$];
        mode_t scan;
        logic [CNT_W-1:0] held;
        logic latched;
        int unsigned mismatch_count;
        string keyword;

        function new();
            keyword = "print";
            scan = MODE_START;
            held = '0;
            latched = 1'b0;
            mismatch_count = 0;
        endfunction

        static function bit digit_byte(logic [CHAR_W-1:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        static function bit letter_byte(logic [CHAR_W-1:0] c);
            return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        endfunction

        static function bit blank_byte(logic [CHAR_W-1:0] c);
            return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        endfunction

        // KIND_ERROR means not a one-byte operator
        static function logic [KIND_W-1:0] punct_kind(logic [CHAR_W-1:0] c);
            case (c)
                "+": return KIND_PLUS;
                "-": return KIND_MINUS;
                "*": return KIND_STAR;
                "/": return KIND_SLASH;
                "(": return KIND_LPAREN;
                ")": return KIND_RPAREN;
                "=": return KIND_EQUALS;
                ";": return KIND_SEMI;
                default: return KIND_ERROR;
            endcase
        endfunction

        static function bit known_byte(logic [CHAR_W-1:0] c);
            return digit_byte(c) || letter_byte(c) || blank_byte(c)
                || (punct_kind(c) != KIND_ERROR);
        endfunction

        function void add_token(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic start);
            tok_beat_t t;
            t.token_kind = kind;
            t.char_out = ch;
            t.token_start = start;
            t.last_in_run = 1'b0;
            run_tokens = {run_tokens, t};
        endfunction

        function void flush_prefix();
            logic [CNT_W-1:0] cnt;
            cnt = (held > KW_HELD_MAX) ? KW_HELD_MAX : held;
            for (int unsigned i = 0; i < cnt; i++)
                add_token(KIND_IDENT, keyword[i], i == 0);
            held = '0;
        endfunction

        function void note_source(src_beat_t b);
            logic [CHAR_W-1:0] c;
            bit taken;
            c = b.char_in;
            taken = 1'b0;
            run_tokens.delete();
            if (b.end_of_input)
            begin
                if (!latched && scan == MODE_KW)
                    flush_prefix();
                add_token(KIND_END, '0, 1'b1);
                scan = MODE_START;
                held = '0;
                latched = 1'b0;
            end
            else if (!latched)
            begin
                if (scan == MODE_KW)
                begin
                    if (held < KW_LEN && c == keyword[held])
                    begin
                        held = held + 1'b1;
                        taken = 1'b1;
                        if (held == KW_LEN)
                        begin
                            for (int i = 0; i < KW_LEN; i++)
                                add_token(KIND_PRINT, keyword[i], i == 0);
                            scan = MODE_START;
                            held = '0;
                        end
                    end
                    else
                    begin
                        flush_prefix();
                        scan = MODE_IDENT;
                    end
                end
                if (!taken && scan == MODE_NUM)
                begin
                    if (digit_byte(c))
                    begin
                        add_token(KIND_NUMBER, c, 1'b0);
                        taken = 1'b1;
                    end
                    else
                        scan = MODE_START;
                end
                if (!taken && scan == MODE_IDENT)
                begin
                    if (letter_byte(c) || digit_byte(c) || c == CH_UNDERSCORE)
                    begin
                        add_token(KIND_IDENT, c, 1'b0);
                        taken = 1'b1;
                    end
                    else
                        scan = MODE_START;
                end
                if (!taken)
                begin
                    if (blank_byte(c))
                        taken = 1'b1;
                    else if (digit_byte(c))
                    begin
                        add_token(KIND_NUMBER, c, 1'b1);
                        scan = MODE_NUM;
                    end
                    else if (punct_kind(c) != KIND_ERROR)
                        add_token(punct_kind(c), c, 1'b1);
                    else if (c == keyword[0])
                    begin
                        scan = MODE_KW;
                        held = 3'd1;
                    end
                    else if (letter_byte(c))
                    begin
                        add_token(KIND_IDENT, c, 1'b1);
                        scan = MODE_IDENT;
                    end
                    else
                    begin
                        add_token(KIND_ERROR, c, 1'b1);
                        latched = 1'b1;
                        scan = MODE_START;
                        held = '0;
                    end
                end
            end
            if (run_tokens.size() > 0)
                run_tokens[run_tokens.size() - 1].last_in_run = 1'b1;
            pending_tokens = {pending_tokens, run_tokens};
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= 60)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_token(tok_beat_t got);
            tok_beat_t want;
            if (pending_tokens.size() == 0)
            begin
                report($sformatf("token beat with none pending: kind %0d char %02h",
                                 got.token_kind, got.char_out));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report($sformatf("token_kind got %0d want %0d (char %02h)",
                                 got.token_kind, want.token_kind, want.char_out));
            if (got.char_out !== want.char_out)
                report($sformatf("char_out got %02h want %02h", got.char_out, want.char_out));
            if (got.token_start !== want.token_start)
                report($sformatf("token_start got %b want %b (char %02h)",
                                 got.token_start, want.token_start, want.char_out));
            if (got.last_in_run !== want.last_in_run)
                report($sformatf("last_in_run got %b want %b (char %02h)",
                                 got.last_in_run, want.last_in_run, want.char_out));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    src_beat_t src_beat;
    logic tok_valid;
    logic tok_stall;
    tok_beat_t tok_beat;

    token_tracker tracker;
    int unsigned src_gap_pct = 0;
    int unsigned sink_gap_pct = 0;
    int unsigned hold_left = 0;

    expression_lexer uut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_beat(src_beat),
        .tok_valid(tok_valid),
        .tok_stall(tok_stall),
        .tok_beat(tok_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_beat(input src_beat_t b);
        while ($urandom_range(99) < src_gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_beat <= b;
        do
            @(posedge clk);
        while (src_stall);
        tracker.note_source(b);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        src_beat_t b;
        b.char_in = c;
        b.end_of_input = 1'b0;
        send_beat(b);
    endtask

    task automatic send_end();
        src_beat_t b;
        b.char_in = CHAR_W'($urandom);
        b.end_of_input = 1'b1;
        send_beat(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        return $urandom_range(1) ? CHAR_W'(8'h61 + $urandom_range(25))
                                 : CHAR_W'(8'h41 + $urandom_range(25));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_name_char();
        case ($urandom_range(3))
            0: return CHAR_W'(8'h30 + $urandom_range(9));
            1: return CH_UNDERSCORE;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] rand_op();
        string ops;
        ops = "+-*/()=;";
        return ops[$urandom_range(7)];
    endfunction

    function automatic logic [CHAR_W-1:0] rand_blank();
        int unsigned i;
        i = $urandom_range(5);
        return (i == 5) ? CH_SPACE : CHAR_W'(CH_TAB + i);
    endfunction

    task automatic send_random_token(inout int unsigned sent);
        int unsigned pick;
        int unsigned len;
        logic [CHAR_W-1:0] c;
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            len = $urandom_range(4, 1);
            for (int unsigned i = 0; i < len; i++)
                send_char(CHAR_W'(8'h30 + $urandom_range(9)));
            sent += len;
        end
        else if (pick < 36)
        begin
            len = $urandom_range(4);
            send_char(rand_letter());
            for (int unsigned i = 0; i < len; i++)
                send_char(rand_name_char());
            sent += len + 1;
        end
        else if (pick < 50)
        begin
            send_text(tracker.keyword);
            sent += 5;
            if ($urandom_range(1))
            begin
                send_char(rand_name_char());
                sent++;
            end
        end
        else if (pick < 60)
        begin
            len = $urandom_range(4, 1);
            for (int unsigned i = 0; i < len; i++)
                send_char(tracker.keyword[i]);
            case ($urandom_range(2))
                0: send_char(rand_name_char());
                1: send_char(rand_op());
                default: send_char(rand_blank());
            endcase
            sent += len + 1;
        end
        else if (pick < 78)
        begin
            send_char(rand_op());
            sent++;
        end
        else if (pick < 90)
        begin
            send_char(rand_blank());
            sent++;
        end
        else if (pick < 96)
        begin
            // end of input, sometimes with a keyword prefix still held
            if ($urandom_range(1))
            begin
                len = $urandom_range(4, 1);
                for (int unsigned i = 0; i < len; i++)
                    send_char(tracker.keyword[i]);
                sent += len;
            end
            send_end();
            sent++;
        end
        else
        begin
            if ($urandom_range(3) == 0)
                c = CH_UNDERSCORE;
            else
                do
                    c = CHAR_W'($urandom_range(255));
                while (token_tracker::known_byte(c));
            send_char(c);
            // random bytes, dropped if the error is latched
            len = $urandom_range(2);
            for (int unsigned i = 0; i < len; i++)
                send_char(CHAR_W'($urandom_range(255)));
            send_end();
            sent += len + 2;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (tok_valid && !tok_stall)
                tracker.check_token(tok_beat);
            if (hold_left != 0)
            begin
                tok_stall <= 1'b1;
                hold_left--;
            end
            else
                tok_stall <= ($urandom_range(99) < sink_gap_pct);
        end
    end

    initial
    begin
        int unsigned sent;
        tracker = new();
        rst_n <= 1'b0;
        src_valid <= 1'b0;
        src_beat <= '0;
        tok_stall <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: keyword, names, numbers, operators, blanks, prefix fallback, errors
        src_gap_pct = 30;
        sink_gap_pct = 30;
        send_text("printZ_9\t09+-*/()=;");
        send_char(CH_CR);
        send_text("pr_");
        send_text("p");
        send_end();
        send_char(CH_UNDERSCORE);
        send_char(8'hFF);
        send_end();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_gap_pct = 20;
                    sink_gap_pct = 50;
                end
                1:
                begin
                    src_gap_pct = 50;
                    sink_gap_pct = 20;
                end
                default:
                begin
                    src_gap_pct = 0;
                    sink_gap_pct = 0;
                    hold_left = 120;
                end
            endcase
            sent = 0;
            while (sent < 130)
                send_random_token(sent);
        end
        src_valid <= 1'b0;

        while (tracker.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("expression_lexer verification clean");
        else
            $display("expression_lexer verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("expression_lexer verification failed");
        $finish;
    end

endmodule
